@@ sv/adbm_pkg.sv @@
// ============================================================================
// ADPCM-B decode and mix package
// Shared widths, sequencer states, multiplier request type, constants and step factor table.
// ============================================================================
`default_nettype none

package adbm_pkg;

    localparam int SMP_W   = 16;
    localparam int STEP_W  = 15;
    localparam int VOL_W   = 16;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

    localparam logic [STEP_W-1:0] STEP_MIN   = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MAX   = 15'd24576;
    localparam logic [VOL_W-1:0]  VOL_RESET  = 16'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_STEP,
        ST_VOL,
        ST_MIX
    } adbm_state_t;

    // One request to the shared multiplier. The product is captured when en is high.
    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic        [MUL_B_W-1:0] b;
    } mul_req_t;

    // Step adaptation factor, indexed by the three magnitude bits of a code.
    function automatic logic [7:0] step_factor(input logic [2:0] mag);
        logic [7:0] f;
        case (mag)
            3'd4:    f = 8'd77;
            3'd5:    f = 8'd102;
            3'd6:    f = 8'd128;
            3'd7:    f = 8'd153;
            default: f = 8'd57;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

@@ sv/adbm_mul.sv @@
// ============================================================================
// ADPCM-B shared multiplier
// Signed by unsigned multiplier with a registered product, shared by the
// delta, step update and volume scaling passes.
// ============================================================================
`default_nettype none

module adbm_mul (
    input  wire                          clk,
    input  wire adbm_pkg::mul_req_t      req,
    output logic signed [adbm_pkg::PROD_W-1:0] prod
);
    import adbm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = $signed({{(PROD_W-MUL_A_W){req.a[MUL_A_W-1]}}, req.a})
                     * $signed({{(PROD_W-MUL_B_W){1'b0}}, req.b});

    // The product only moves when a new operand pair is issued.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ sv/adpcm_b_decode_mix.sv @@
// ============================================================================
// ADPCM-B decoder with volume-scaled mixing
// Decodes two 4-bit codes per request and mixes each sample into a buffer value.
// ============================================================================
// Sequence: after a request is accepted, the first result passes the delta, step, volume
// and mix states into the output register; the second repeats them once the first is loaded,
// or loads at the edge the first is taken if later. Per nibble three shared multiplier passes
// (delta, step update, volume) and a mix state; a new code byte is taken only when idle.
// Reset: rst_n clears the sequencer, step size to 127, history to 0, volume to 256.
`default_nettype none

module adpcm_b_decode_mix (
    input  wire                              clk,
    input  wire                              rst_n,
    // Volume register write port.
    input  wire                              cfg_we,
    input  wire  [adbm_pkg::VOL_W-1:0]       cfg_wdata,
    // Request channel.
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [7:0]                       code_byte,
    input  wire  signed [adbm_pkg::SMP_W-1:0] mix_first,
    input  wire  signed [adbm_pkg::SMP_W-1:0] mix_second,
    input  wire                              restart,
    // Result channel.
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic signed [adbm_pkg::SMP_W-1:0] mixed_sample,
    output logic signed [adbm_pkg::SMP_W-1:0] decoded_sample,
    output logic                             second_nibble
);
    import adbm_pkg::*;

    // Sequencer and decoder state.
    adbm_state_t              state_reg, state_next;
    logic                     nib_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [SMP_W-1:0]  hist_reg;
    logic [VOL_W-1:0]         vol_reg;

    // Captured request payload.
    logic [7:0]               code_reg;
    logic signed [SMP_W-1:0]  mix0_reg;
    logic signed [SMP_W-1:0]  mix1_reg;

    // Output register.
    logic                     out_valid_reg;
    logic signed [SMP_W-1:0]  out_mixed_reg;
    logic signed [SMP_W-1:0]  out_dec_reg;
    logic                     out_nib_reg;

    mul_req_t                 mul_req;
    logic signed [PROD_W-1:0] prod;

    adbm_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // The code of the nibble in flight: high nibble first, then low nibble.
    logic [3:0]               nib_code;
    logic signed [SMP_W-1:0]  nib_mix;
    assign nib_code = nib_reg ? code_reg[3:0] : code_reg[7:4];
    assign nib_mix  = nib_reg ? mix1_reg : mix0_reg;

    // History update: the delta is the product over 8 (at most 16 bits, never
    // negative); it is added or subtracted and the result saturates to 16 bits.
    logic signed [19:0]       hist_sum;
    logic signed [SMP_W-1:0]  hist_sat;
    always_comb
    begin
        if (nib_code[3])
        begin
            hist_sum = 20'(hist_reg) - $signed({4'b0000, prod[18:3]});
        end
        else
        begin
            hist_sum = 20'(hist_reg) + $signed({4'b0000, prod[18:3]});
        end
        if (hist_sum > 20'sd32767)
        begin
            hist_sat = 16'sh7FFF;
        end
        else if (hist_sum < -20'sd32768)
        begin
            hist_sat = -16'sh8000;
        end
        else
        begin
            hist_sat = hist_sum[SMP_W-1:0];
        end
    end

    // Step update: factor times step over 64, clamped to the legal range.
    logic [15:0]       step_raw;
    logic [STEP_W-1:0] step_clamped;
    always_comb
    begin
        step_raw = prod[21:6];
        if (step_raw < 16'(STEP_MIN))
        begin
            step_clamped = STEP_MIN;
        end
        else if (step_raw > 16'(STEP_MAX))
        begin
            step_clamped = STEP_MAX;
        end
        else
        begin
            step_clamped = step_raw[STEP_W-1:0];
        end
    end

    // Mix: the arithmetic shift of the volume product floors toward minus
    // infinity, then the sum with the buffer sample saturates to 16 bits.
    logic signed [PROD_W-9:0] scaled;
    logic signed [PROD_W-8:0] mix_sum;
    logic signed [SMP_W-1:0]  mix_sat;
    always_comb
    begin
        scaled  = prod[PROD_W-1:8];
        mix_sum = (PROD_W-7)'(nib_mix) + (PROD_W-7)'(scaled);
        if (mix_sum > (PROD_W-7)'(32767))
        begin
            mix_sat = 16'sh7FFF;
        end
        else if (mix_sum < -(PROD_W-7)'(32768))
        begin
            mix_sat = -16'sh8000;
        end
        else
        begin
            mix_sat = mix_sum[SMP_W-1:0];
        end
    end

    logic in_fire;
    logic out_load;
    assign in_fire  = in_valid && in_ready;
    // A result is loaded only when the output register is empty or being emptied.
    assign out_load = (state_reg == ST_MIX) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer: three multiplier passes and a mix pass per nibble, two
    // nibbles per request.
    always_comb
    begin
        state_next  = state_reg;
        mul_req.en  = 1'b0;
        mul_req.a   = '0;
        mul_req.b   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                // (1 + 2*mag) * step
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'({nib_code[2:0], 1'b1});
                mul_req.b  = MUL_B_W'(step_reg);
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                // factor * step, while the delta product updates the history
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(step_factor(nib_code[2:0]));
                mul_req.b  = MUL_B_W'(step_reg);
                state_next = ST_VOL;
            end
            ST_VOL:
            begin
                // history * volume, while the step product updates the step
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(hist_reg);
                mul_req.b  = vol_reg;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (out_load)
                begin
                    state_next = nib_reg ? ST_IDLE : ST_DELTA;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_reg       <= 1'b0;
            step_reg      <= STEP_MIN;
            hist_reg      <= '0;
            vol_reg       <= VOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vol_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                nib_reg <= 1'b0;
                if (restart)
                begin
                    step_reg <= STEP_MIN;
                    hist_reg <= '0;
                end
            end
            if (state_reg == ST_STEP)
            begin
                hist_reg <= hist_sat;
            end
            if (state_reg == ST_VOL)
            begin
                step_reg <= step_clamped;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                nib_reg       <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            code_reg <= code_byte;
            mix0_reg <= mix_first;
            mix1_reg <= mix_second;
        end
        if (out_load)
        begin
            out_mixed_reg <= mix_sat;
            out_dec_reg   <= hist_reg;
            out_nib_reg   <= nib_reg;
        end
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign mixed_sample   = out_mixed_reg;
    assign decoded_sample = out_dec_reg;
    assign second_nibble  = out_nib_reg;

`ifndef SYNTHESIS
    // The adapted step never leaves its clamp range.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg >= STEP_MIN) && (step_reg <= STEP_MAX))
        else $error("step size out of range");

    // A restart request clears the decoder state before the first nibble.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && restart) |=> (hist_reg == '0) && (step_reg == STEP_MIN))
        else $error("restart did not clear decoder state");

    // Loading the low-nibble result ends the request.
    a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && nib_reg) |=> (state_reg == ST_IDLE) && out_nib_reg)
        else $error("request did not finish after second result");

    // A blocked output holds the sequencer in the mix pass.
    a_mix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX && out_valid_reg && !out_ready) |=> (state_reg == ST_MIX))
        else $error("result overwritten while output stalled");
`endif

endmodule

`default_nettype wire
